// ----- hw/rtl/brb_pkg.sv -----
// -----------------------------------------------------------------------------
// brb_pkg
// shared constants for the block reversal buffer
// -----------------------------------------------------------------------------
package brb_pkg;

	localparam int unsigned BLOCK_DEPTH_DEF    = 32;
	localparam int unsigned SYMBOL_BITS_DEF    = 16;
	localparam int unsigned REMAINDER_BITS_DEF = 4;

endpackage

// ----- hw/rtl/brb_ram.sv -----
// -----------------------------------------------------------------------------
// brb_ram
// generic single write port, single read port ram with registered read data
// -----------------------------------------------------------------------------
module brb_ram #(
	parameter int unsigned WIDTH = brb_pkg::SYMBOL_BITS_DEF,
	parameter int unsigned DEPTH = brb_pkg::BLOCK_DEPTH_DEF,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/block_reversal_buffer_unit.sv -----
// -----------------------------------------------------------------------------
// block_reversal_buffer_unit
// collects symbols into a block and plays each block back newest first
// -----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per symbol with its data,
// remainder tag and end-of-stream flag. Words are written in arrival order
// into a block ram, one per cycle while in_ready is high. A block closes on
// the word that fills it (BLOCK_DEPTH words) or on a word with end_of_stream set.
// Output channel (out_valid/out_ready): after a close, the block is read back
// from the newest entry down to entry zero, one ram read per cycle while the
// receiver keeps up. Every output word carries the closing word's remainder
// tag and end flag; run_last marks the word from entry zero.
// After the closing word is accepted, the first output word of a block passes
// through the ram read data register and then the output register; the rest
// follow one per cycle while out_ready is high. in_ready is low from the close
// until the last ram read of the block is issued, so the single block ram
// cannot accept a new block while the previous one is still being read back.
// A stalled receiver holds the output register; the ram read data register
// acts as the skid stage, and reads stop until it drains.
// Reset (arst_n low) drops the open block and any words not yet delivered.
// -----------------------------------------------------------------------------
module block_reversal_buffer_unit #(
	parameter int unsigned BLOCK_DEPTH    = brb_pkg::BLOCK_DEPTH_DEF,
	parameter int unsigned SYMBOL_BITS    = brb_pkg::SYMBOL_BITS_DEF,
	parameter int unsigned REMAINDER_BITS = brb_pkg::REMAINDER_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SYMBOL_BITS-1:0]    symbol_data,
	input  logic [REMAINDER_BITS-1:0] remainder_tag,
	input  logic                      end_of_stream,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SYMBOL_BITS-1:0]    symbol_out,
	output logic [REMAINDER_BITS-1:0] block_remainder,
	output logic                      run_last,
	output logic                      closed_by_end
);

	localparam int unsigned AW = $clog2(BLOCK_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(BLOCK_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_FILL  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t state_q;

	logic [AW-1:0]             fill_q;
	logic [AW-1:0]             rd_ptr_q;
	logic [REMAINDER_BITS-1:0] blk_tag_q;
	logic                      blk_eos_q;

	// read stage: ram data register plus its side info
	logic                      rd_vld_s1;
	logic [REMAINDER_BITS-1:0] tag_s1;
	logic                      eos_s1;
	logic                      last_s1;
	logic [SYMBOL_BITS-1:0]    rdata;

	logic                      out_vld_q;
	logic [SYMBOL_BITS-1:0]    sym_q;
	logic [REMAINDER_BITS-1:0] tag_q;
	logic                      last_q;
	logic                      eos_q;

	logic in_acc;
	logic close;
	logic move;
	logic rd_issue;

	assign in_ready = (state_q == ST_FILL);
	assign in_acc   = in_valid && in_ready;
	assign close    = end_of_stream || (fill_q == LAST_SLOT);
	assign move     = rd_vld_s1 && (!out_vld_q || out_ready);
	// interlock: a read is issued only when its data register is free next cycle
	assign rd_issue = (state_q == ST_DRAIN) && (!rd_vld_s1 || move);

	brb_ram #(
		.WIDTH(SYMBOL_BITS),
		.DEPTH(BLOCK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (in_acc),
		.waddr(fill_q),
		.wdata(symbol_data),
		.re   (rd_issue),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			fill_q    <= '0;
			rd_ptr_q  <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (in_acc) begin
						if (close) begin
							state_q  <= ST_DRAIN;
							rd_ptr_q <= fill_q;
							fill_q   <= '0;
						end else begin
							fill_q <= fill_q + AW'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (rd_issue) begin
						if (rd_ptr_q == '0) begin
							state_q <= ST_FILL;
						end else begin
							rd_ptr_q <= rd_ptr_q - AW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase

			if (rd_issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (move) begin
				rd_vld_s1 <= 1'b0;
			end

			if (move) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && close) begin
			blk_tag_q <= remainder_tag;
			blk_eos_q <= end_of_stream;
		end
		if (rd_issue) begin
			tag_s1  <= blk_tag_q;
			eos_s1  <= blk_eos_q;
			last_s1 <= (rd_ptr_q == '0);
		end
		if (move) begin
			sym_q  <= rdata;
			tag_q  <= tag_s1;
			eos_q  <= eos_s1;
			last_q <= last_s1;
		end
	end

	assign out_valid       = out_vld_q;
	assign symbol_out      = sym_q;
	assign block_remainder = tag_q;
	assign run_last        = last_q;
	assign closed_by_end   = eos_q;

	// ram data register must hold while its word waits for the output register
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && !move) |=> (rd_vld_s1 && $stable(rdata)))
		else $error("pending read data lost");

	// no read may be issued while the block is still filling
	a_no_read_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (state_q == ST_DRAIN && !in_acc))
		else $error("read issued during fill");

	// a closing word starts playback at its own slot
	a_close_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && close) |=> (state_q == ST_DRAIN && fill_q == '0 && !in_ready))
		else $error("close did not start playback");

	// the final read of a block carries the run_last mark
	a_last_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && rd_ptr_q == '0) |=> (rd_vld_s1 && last_s1 && state_q == ST_FILL))
		else $error("run_last not set on entry zero");

endmodule
